@@ hw/rtl/ordered_job_table_core_defines.svh @@
// Assertion macros for the ordered job table RTL.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ORDERED_JOB_TABLE_CORE_DEFINES_SVH
`define ORDERED_JOB_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop on every rising clock edge outside reset.
`define OJT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that cond never holds outside reset.
`define OJT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define OJT_ASSERT(lbl, prop, msg)
`define OJT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ hw/rtl/ojt_pkg.sv @@
// Shared types and constants of the ordered job table.
// No dependencies; used by ojt_match_unit and ordered_job_table_core.
package ojt_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int REQ_W        = 4;
  localparam int PID_W        = 22;
  localparam int POS_W        = 5;
  localparam int TIME_W       = 32;
  localparam int STATUS_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD       = 4'd0,
    REQ_REMOVE    = 4'd1,
    REQ_SET_SUSP  = 4'd2,
    REQ_TO_BG     = 4'd3,
    REQ_TO_FG     = 4'd4,
    REQ_FIND_PID  = 4'd5,
    REQ_FIND_POS  = 4'd6,
    REQ_LAST_SUSP = 4'd7,
    REQ_FIRST_FG  = 4'd8
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic              suspended;
    logic              background;
    logic [TIME_W-1:0] start;
  } job_t;

  typedef struct packed {
    req_e             req;
    logic [PID_W-1:0] pid;
  } match_ctrl_t;

endpackage

@@ hw/rtl/ojt_match_unit.sv @@
// Shared entry test of the ordered job table scan: pid match or flag test.
// Depends on ojt_pkg.
module ojt_match_unit import ojt_pkg::*; (
  input  match_ctrl_t ctrl_i,
  input  job_t        entry_i,
  output logic        hit_o
);

  always_comb begin
    case (ctrl_i.req)
      REQ_REMOVE,
      REQ_SET_SUSP,
      REQ_TO_BG,
      REQ_TO_FG,
      REQ_FIND_PID:  hit_o = (entry_i.pid == ctrl_i.pid);
      REQ_LAST_SUSP: hit_o = entry_i.suspended;
      REQ_FIRST_FG:  hit_o = !entry_i.background;
      default:       hit_o = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/ordered_job_table_core.sv @@
// Ordered job table: entry memory, scan/compaction sequencer and result register.
// Depends on ojt_pkg, ojt_match_unit and ordered_job_table_core_defines.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type, proc_id, position, flag_value,
//          |           |                        | now_time
//  out     | output    | out_valid_o/out_stall_i | status, job_position, job_pid,
//          |           |                        | job_suspended, job_background, job_start,
//          |           |                        | job_count
//
// Add writes the new entry at the tail; find by position reads one entry. Pid and flag
// searches read one entry a cycle through the single read port of the entry memory and the
// shared match unit; remove then closes the gap, one entry moved per cycle. The input stalls
// from acceptance until the result is loaded into the output register, which may still hold
// an untaken transaction while the next one runs. Reset clears state, count and valid flags
// only; entry memory is not cleared.
`include "ordered_job_table_core_defines.svh"

module ordered_job_table_core import ojt_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [PID_W-1:0]  proc_id_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic              flag_value_i,
  input  logic [TIME_W-1:0] now_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]  job_position_o,
  output logic [PID_W-1:0]  job_pid_o,
  output logic              job_suspended_o,
  output logic              job_background_o,
  output logic [TIME_W-1:0] job_start_o,
  output logic [POS_W-1:0]  job_count_o
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               pv_q, pv_d;
  logic [IDX_W-1:0]   pidx_q, pidx_d;
  req_e               req_q, req_d;
  logic [PID_W-1:0]   pid_q, pid_d;
  logic               flag_q, flag_d;

  status_e            res_status_q, res_status_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  job_t               res_ent_q, res_ent_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [POS_W-1:0]   out_pos_q;
  job_t               out_ent_q;
  logic [POS_W-1:0]   out_cnt_q;

  job_t               mem_q [MAX_JOBS];
  job_t               rd_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  job_t               mem_wdata;

  logic               accept, table_full, pos_ok, scan_hit, out_free, load_out;
  logic               scan_hit_raw;
  req_e               in_req;
  match_ctrl_t        match_ctrl;
  job_t               upd_ent;
  logic [CNT_W-1:0]   slot_pos;

  assign in_req     = req_e'(req_type_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign table_full = (cnt_q == CNT_W'(MAX_JOBS));
  assign pos_ok     = (position_i != '0) && (CMP_W'(position_i) <= CMP_W'(cnt_q));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_DONE) && out_free;
  assign slot_pos   = CNT_W'(pidx_q) + CNT_W'(1);

  assign match_ctrl = '{req: req_q, pid: pid_q};

  ojt_match_unit u_match (
    .ctrl_i  (match_ctrl),
    .entry_i (rd_q),
    .hit_o   (scan_hit_raw)
  );

  assign scan_hit = pv_q && scan_hit_raw;

  // Flag updates applied to the matched entry.
  always_comb begin
    upd_ent = rd_q;
    case (req_q)
      REQ_SET_SUSP: upd_ent.suspended  = flag_q;
      REQ_TO_BG:    upd_ent.background = 1'b1;
      REQ_TO_FG:    upd_ent.background = 1'b0;
      default:      upd_ent = rd_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req)
            REQ_ADD:       state_d = S_DONE;
            REQ_FIND_POS:  state_d = pos_ok ? S_READ : S_DONE;
            REQ_REMOVE,
            REQ_SET_SUSP,
            REQ_TO_BG,
            REQ_TO_FG,
            REQ_FIND_PID,
            REQ_LAST_SUSP,
            REQ_FIRST_FG:  state_d = S_SCAN;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_d = (req_q == REQ_REMOVE) ? S_SHIFT : S_DONE;
        end else if (rem_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (rem_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_READ: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    rem_d        = rem_q;
    pv_d         = pv_q;
    pidx_d       = pidx_q;
    req_d        = req_q;
    pid_d        = pid_q;
    flag_d       = flag_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_ent_d    = res_ent_q;
    mem_we       = 1'b0;
    mem_waddr    = pidx_q;
    mem_wdata    = rd_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d        = in_req;
          pid_d        = proc_id_i;
          flag_d       = flag_value_i;
          pv_d         = 1'b0;
          rem_d        = cnt_q;
          idx_d        = '0;
          res_status_d = STAT_NOT_FOUND;
          res_pos_d    = '0;
          res_ent_d    = '0;
          case (in_req)
            REQ_ADD: begin
              if (table_full) begin
                res_status_d = STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = IDX_W'(cnt_q);
                mem_wdata    = '{pid: proc_id_i, suspended: flag_value_i,
                                 background: 1'b0, start: now_time_i};
                res_ent_d    = mem_wdata;
                res_status_d = STAT_OK;
                res_pos_d    = POS_W'(cnt_q + CNT_W'(1));
                cnt_d        = cnt_q + CNT_W'(1);
              end
            end
            REQ_FIND_POS: begin
              if (pos_ok) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(position_i - POS_W'(1));
                pidx_d    = mem_raddr;
              end
            end
            // walk from the tail toward position one
            REQ_LAST_SUSP: idx_d = IDX_W'(cnt_q - CNT_W'(1));
            default: idx_d = '0;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_status_d = STAT_OK;
          res_pos_d    = POS_W'(slot_pos);
          res_ent_d    = rd_q;
          pv_d         = 1'b0;
          case (req_q)
            REQ_REMOVE: begin
              // report the job as it was, then close the gap
              idx_d = pidx_q + IDX_W'(1);
              rem_d = cnt_q - slot_pos;
              cnt_d = cnt_q - CNT_W'(1);
            end
            REQ_SET_SUSP,
            REQ_TO_BG,
            REQ_TO_FG: begin
              mem_we    = 1'b1;
              mem_waddr = pidx_q;
              mem_wdata = upd_ent;
              res_ent_d = upd_ent;
            end
            default: res_ent_d = rd_q;
          endcase
        end else if (rem_q != '0) begin
          mem_re = 1'b1;
          pidx_d = idx_q;
          pv_d   = 1'b1;
          rem_d  = rem_q - CNT_W'(1);
          idx_d  = (req_q == REQ_LAST_SUSP) ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // move the entry read last cycle up one slot
        if (pv_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q - IDX_W'(1);
          mem_wdata = rd_q;
        end
        if (rem_q != '0) begin
          mem_re = 1'b1;
          pidx_d = idx_q;
          pv_d   = 1'b1;
          rem_d  = rem_q - CNT_W'(1);
          idx_d  = idx_q + IDX_W'(1);
        end else begin
          pv_d = 1'b0;
        end
      end
      S_READ: begin
        res_status_d = STAT_OK;
        res_pos_d    = POS_W'(slot_pos);
        res_ent_d    = rd_q;
      end
      default: begin
        pv_d = pv_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    rem_q        <= rem_d;
    pidx_q       <= pidx_d;
    req_q        <= req_d;
    pid_q        <= pid_d;
    flag_q       <= flag_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_ent_q    <= res_ent_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_ent_q    <= res_ent_q;
      out_cnt_q    <= POS_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign job_position_o   = out_pos_q;
  assign job_pid_o        = out_ent_q.pid;
  assign job_suspended_o  = out_ent_q.suspended;
  assign job_background_o = out_ent_q.background;
  assign job_start_o      = out_ent_q.start;
  assign job_count_o      = out_cnt_q;

  `OJT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_JOBS), "job count above table depth")
  `OJT_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CNT_W'(1)) || ($past(cnt_q) == cnt_q + CNT_W'(1))), "job count moved by more than one")
  `OJT_ASSERT(a_out_load, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result shown without a finished request")
  `OJT_ASSERT_NEVER(a_shift_req, (state_q == S_SHIFT) && (req_q != REQ_REMOVE), "compaction outside a remove")
  `OJT_ASSERT_NEVER(a_shift_src, (state_q == S_SHIFT) && pv_q && (pidx_q == '0), "compaction source at slot zero")

endmodule
